### hw/rtl/hstct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hstct_pkg
// Shared widths, register indexes and reset values of the Hall sample to
// conductivity tensor block.
// ----------------------------------------------------------------------------
package hstct_pkg;

  // Field widths
  localparam int unsigned VoltW  = 24;
  localparam int unsigned RatioW = 24;
  localparam int unsigned ThickW = 20;
  localparam int unsigned CurW   = 20;
  localparam int unsigned LimW   = 10;
  localparam int unsigned OutW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Number of quotient bits each divider produces, one per stage
  localparam int unsigned QuotW = 32;

  // Register reset values
  localparam logic [RatioW-1:0] RatioRst = 24'd65536;
  localparam logic [ThickW-1:0] ThickRst = 20'd10000;
  localparam logic [CurW-1:0]   CurRst   = 20'd1000000;
  localparam logic [LimW-1:0]   LimRst   = 10'd1;

  // Saturation bounds of a Q16.16 magnitude
  localparam logic [OutW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0] NegMax = 32'h8000_0000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LENGTH_RATIO    = 2'd0,
    CFG_FILM_THICKNESS  = 2'd1,
    CFG_DRIVE_CURRENT   = 2'd2,
    CFG_NEAR_ZERO_LIMIT = 2'd3
  } cfg_index_e;

endpackage : hstct_pkg
`default_nettype wire

### hw/rtl/hall_signal_to_conductivity_tensor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hall_signal_to_conductivity_tensor_top
// Converts one Hall sample per cycle into effective conductivity, effective
// Hall coefficient and the two conductivity tensor components (Q16.16).
// ----------------------------------------------------------------------------
// A sample is taken at every clock edge with start_i high; busy_o stays low,
// so one sample per cycle is sustained. Each result word appears on the result
// ports for one cycle with valid_o high, in sample order; the receiver cannot
// stall, so results must be taken as they come. The pipeline holds two chains
// of 32 one-bit restoring divider stages (conductivity/Hall coefficient, then
// the tensor pair) with the saturate, product and partial-product stages
// between them. Configuration words are always accepted (cfg_ready_o high) and
// must only be written while no sample is in flight.
module hall_signal_to_conductivity_tensor_top
  import hstct_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // sample command
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic signed [VoltW-1:0] long_voltage_i,
  input  wire logic signed [VoltW-1:0] hall_voltage_i,
  input  wire logic                 sweep_end_i,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  // result
  output logic                      valid_o,
  output logic signed [OutW-1:0]    eff_conductivity_o,
  output logic signed [OutW-1:0]    eff_hall_coeff_o,
  output logic signed [OutW-1:0]    tensor_xx_o,
  output logic signed [OutW-1:0]    tensor_xy_o,
  output logic                      small_signal_o,
  output logic                      saturated_o,
  output logic                      sweep_last_o
);

  // --------------------------------------------------------------------------
  // Types of the divider chains
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [43:0] rem_s;
    logic [31:0] lo_s;
    logic [43:0] den_s;
    logic [31:0] q_s;
    logic        ovf_s;
    logic [19:0] rem_r;
    logic [31:0] lo_r;
    logic [31:0] q_r;
    logic        ovf_r;
    logic        vneg;
    logic        hneg;
    logic        near_zero;
    logic        sweep;
  } div1_t;

  typedef struct packed {
    logic [125:0] rem_xx;
    logic [125:0] rem_xy;
    logic [125:0] den;
    logic [31:0]  q_xx;
    logic [31:0]  q_xy;
    logic         sneg;
    logic         rneg;
    logic [31:0]  s;
    logic [31:0]  r;
    logic         near_zero;
    logic         sat;
    logic         sweep;
  } div2_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RatioW-1:0] ratio_q;
  logic [ThickW-1:0] thick_q;
  logic [CurW-1:0]   cur_q;
  logic [LimW-1:0]   lim_q;
  logic [ThickW-1:0] thick_eff;
  logic [CurW-1:0]   cur_eff;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Write a register on each accepted word; mask data to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioRst;
      thick_q <= ThickRst;
      cur_q   <= CurRst;
      lim_q   <= LimRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LENGTH_RATIO:    ratio_q <= cfg_data_i[RatioW-1:0];
        CFG_FILM_THICKNESS:  thick_q <= cfg_data_i[ThickW-1:0];
        CFG_DRIVE_CURRENT:   cur_q   <= cfg_data_i[CurW-1:0];
        CFG_NEAR_ZERO_LIMIT: lim_q   <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Treat a zero thickness or current as one
  assign thick_eff = (thick_q == '0) ? ThickW'(1) : thick_q;
  assign cur_eff   = (cur_q == '0) ? CurW'(1) : cur_q;

  // --------------------------------------------------------------------------
  // Stage 1: capture sample, take magnitudes
  // --------------------------------------------------------------------------
  logic              s1_valid_q;
  logic [VoltW-1:0]  s1_vmag_q, s1_hmag_q;
  logic              s1_vneg_q, s1_hneg_q, s1_sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    s1_vneg_q  <= long_voltage_i[VoltW-1];
    s1_hneg_q  <= hall_voltage_i[VoltW-1];
    s1_vmag_q  <= long_voltage_i[VoltW-1] ? VoltW'(~long_voltage_i + 1'b1)
                                          : VoltW'(long_voltage_i);
    s1_hmag_q  <= hall_voltage_i[VoltW-1] ? VoltW'(~hall_voltage_i + 1'b1)
                                          : VoltW'(hall_voltage_i);
    s1_sweep_q <= sweep_end_i;
  end

  // --------------------------------------------------------------------------
  // Stage 2: form divider operands, detect small signal
  // --------------------------------------------------------------------------
  logic        s2_valid_q;
  logic [43:0] s2_nums_q, s2_dens_q, s2_th_q;
  logic        s2_vneg_q, s2_hneg_q, s2_small_q, s2_sweep_q;
  logic [43:0] nums_d, dens_d, th_d;

  assign nums_d = ratio_q * cur_eff;
  assign dens_d = thick_eff * s1_vmag_q;
  assign th_d   = thick_eff * s1_hmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else         s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s2_nums_q  <= nums_d;
    s2_dens_q  <= dens_d;
    s2_th_q    <= th_d;
    s2_vneg_q  <= s1_vneg_q;
    s2_hneg_q  <= s1_hneg_q;
    s2_small_q <= (s1_vmag_q == '0) || (s1_vmag_q < VoltW'(lim_q));
    s2_sweep_q <= s1_sweep_q;
  end

  // --------------------------------------------------------------------------
  // First divider chain: conductivity and Hall coefficient
  // --------------------------------------------------------------------------
  div1_t       d1_q [0:QuotW];
  logic [QuotW:0] v1_q;

  // Load: flag quotients of 2^32 or more, seed remainders with the high part
  always_ff @(posedge clk_i) begin
    d1_q[0].rem_s     <= {32'd0, s2_nums_q[43:32]};
    d1_q[0].lo_s      <= s2_nums_q[31:0];
    d1_q[0].den_s     <= s2_dens_q;
    d1_q[0].q_s       <= '0;
    d1_q[0].ovf_s     <= {32'd0, s2_nums_q[43:32]} >= s2_dens_q;
    d1_q[0].rem_r     <= s2_th_q[35:16];
    d1_q[0].lo_r      <= {s2_th_q[15:0], 16'd0};
    d1_q[0].q_r       <= '0;
    d1_q[0].ovf_r     <= s2_th_q[43:16] >= 28'(cur_eff);
    d1_q[0].vneg      <= s2_vneg_q;
    d1_q[0].hneg      <= s2_hneg_q;
    d1_q[0].near_zero <= s2_small_q;
    d1_q[0].sweep     <= s2_sweep_q;
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div1
    div1_t       div1_d;
    logic [44:0] tr_s;
    logic [20:0] tr_r;
    logic        ge_s, ge_r;

    // One quotient bit of each division per stage
    always_comb begin
      div1_d = d1_q[k];
      tr_s   = {d1_q[k].rem_s, d1_q[k].lo_s[31]};
      tr_r   = {d1_q[k].rem_r, d1_q[k].lo_r[31]};
      ge_s   = tr_s >= {1'b0, d1_q[k].den_s};
      ge_r   = tr_r >= {1'b0, cur_eff};
      div1_d.rem_s = ge_s ? 44'(tr_s - {1'b0, d1_q[k].den_s}) : tr_s[43:0];
      div1_d.rem_r = ge_r ? 20'(tr_r - {1'b0, cur_eff}) : tr_r[19:0];
      div1_d.lo_s  = {d1_q[k].lo_s[30:0], 1'b0};
      div1_d.lo_r  = {d1_q[k].lo_r[30:0], 1'b0};
      div1_d.q_s   = {d1_q[k].q_s[30:0], ge_s};
      div1_d.q_r   = {d1_q[k].q_r[30:0], ge_r};
    end

    always_ff @(posedge clk_i) begin
      d1_q[k+1] <= div1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= '0;
    else         v1_q <= {v1_q[QuotW-1:0], s2_valid_q};
  end

  // --------------------------------------------------------------------------
  // Saturate stage: clip to Q16.16 range, zero small-signal conductivity, apply signs
  // --------------------------------------------------------------------------
  div1_t       d1_end;
  logic        clip_s, clip_r;
  logic [31:0] smag_d, rmag_d;

  assign d1_end = d1_q[QuotW];

  always_comb begin
    clip_s = d1_end.ovf_s ||
             (d1_end.vneg ? (d1_end.q_s > NegMax) : (d1_end.q_s > PosMax));
    clip_r = d1_end.ovf_r ||
             (d1_end.hneg ? (d1_end.q_r > NegMax) : (d1_end.q_r > PosMax));
    if (d1_end.near_zero) begin
      smag_d = '0;
    end else if (clip_s) begin
      smag_d = d1_end.vneg ? NegMax : PosMax;
    end else begin
      smag_d = d1_end.q_s;
    end
    if (clip_r) begin
      rmag_d = d1_end.hneg ? NegMax : PosMax;
    end else begin
      rmag_d = d1_end.q_r;
    end
  end

  logic        s3_valid_q;
  logic [31:0] s3_smag_q, s3_rmag_q, s3_s_q, s3_r_q;
  logic        s3_sneg_q, s3_rneg_q, s3_small_q, s3_sat_q, s3_sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else         s3_valid_q <= v1_q[QuotW];
  end

  always_ff @(posedge clk_i) begin
    s3_smag_q  <= smag_d;
    s3_rmag_q  <= rmag_d;
    s3_s_q     <= d1_end.vneg ? 32'(~smag_d + 1'b1) : smag_d;
    s3_r_q     <= d1_end.hneg ? 32'(~rmag_d + 1'b1) : rmag_d;
    s3_sneg_q  <= d1_end.vneg;
    s3_rneg_q  <= d1_end.hneg;
    s3_small_q <= d1_end.near_zero;
    s3_sat_q   <= (clip_s && !d1_end.near_zero) || clip_r;
    s3_sweep_q <= d1_end.sweep;
  end

  // --------------------------------------------------------------------------
  // Product stage: p = |S| * |R|
  // --------------------------------------------------------------------------
  logic        s4_valid_q;
  logic [62:0] s4_p_q;
  logic [63:0] p_d;
  logic [31:0] s4_smag_q, s4_s_q, s4_r_q;
  logic        s4_sneg_q, s4_rneg_q, s4_small_q, s4_sat_q, s4_sweep_q;

  assign p_d = s3_smag_q * s3_rmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else         s4_valid_q <= s3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s4_p_q     <= p_d[62:0];
    s4_smag_q  <= s3_smag_q;
    s4_s_q     <= s3_s_q;
    s4_r_q     <= s3_r_q;
    s4_sneg_q  <= s3_sneg_q;
    s4_rneg_q  <= s3_rneg_q;
    s4_small_q <= s3_small_q;
    s4_sat_q   <= s3_sat_q;
    s4_sweep_q <= s3_sweep_q;
  end

  // --------------------------------------------------------------------------
  // Partial-product stage for p^2 and |S| * p
  // --------------------------------------------------------------------------
  logic [30:0] ph;
  logic [31:0] pl;
  logic [61:0] hh_d;
  logic [62:0] hl_d, sh_d;
  logic [63:0] ll_d, sl_d;

  assign ph   = s4_p_q[62:32];
  assign pl   = s4_p_q[31:0];
  assign hh_d = ph * ph;
  assign hl_d = ph * pl;
  assign ll_d = pl * pl;
  assign sh_d = s4_smag_q * ph;
  assign sl_d = s4_smag_q * pl;

  logic        s5_valid_q;
  logic [61:0] s5_hh_q;
  logic [62:0] s5_hl_q, s5_sh_q;
  logic [63:0] s5_ll_q, s5_sl_q;
  logic [31:0] s5_smag_q, s5_s_q, s5_r_q;
  logic        s5_sneg_q, s5_rneg_q, s5_small_q, s5_sat_q, s5_sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_valid_q <= 1'b0;
    else         s5_valid_q <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s5_hh_q    <= hh_d;
    s5_hl_q    <= hl_d;
    s5_ll_q    <= ll_d;
    s5_sh_q    <= sh_d;
    s5_sl_q    <= sl_d;
    s5_smag_q  <= s4_smag_q;
    s5_s_q     <= s4_s_q;
    s5_r_q     <= s4_r_q;
    s5_sneg_q  <= s4_sneg_q;
    s5_rneg_q  <= s4_rneg_q;
    s5_small_q <= s4_small_q;
    s5_sat_q   <= s4_sat_q;
    s5_sweep_q <= s4_sweep_q;
  end

  // --------------------------------------------------------------------------
  // Second divider chain: tensor components
  // --------------------------------------------------------------------------
  div2_t          d2_q [0:QuotW];
  logic [QuotW:0] v2_q;

  // Load: den = p^2 + 2^64, seed remainders with the numerators over 2^32
  always_ff @(posedge clk_i) begin
    d2_q[0].den       <= 126'({s5_hh_q, 64'd0}) + 126'({s5_hl_q, 33'd0}) +
                         126'(s5_ll_q) + (126'd1 << 64);
    d2_q[0].rem_xx    <= 126'({s5_smag_q, 32'd0});
    d2_q[0].rem_xy    <= 126'({s5_sh_q, 32'd0}) + 126'(s5_sl_q);
    d2_q[0].q_xx      <= '0;
    d2_q[0].q_xy      <= '0;
    d2_q[0].sneg      <= s5_sneg_q;
    d2_q[0].rneg      <= s5_rneg_q;
    d2_q[0].s         <= s5_s_q;
    d2_q[0].r         <= s5_r_q;
    d2_q[0].near_zero <= s5_small_q;
    d2_q[0].sat       <= s5_sat_q;
    d2_q[0].sweep     <= s5_sweep_q;
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div2
    div2_t        div2_d;
    logic [126:0] tr_xx, tr_xy;
    logic         ge_xx, ge_xy;

    // Shift in a zero numerator bit, subtract where it fits
    always_comb begin
      div2_d = d2_q[k];
      tr_xx  = {d2_q[k].rem_xx, 1'b0};
      tr_xy  = {d2_q[k].rem_xy, 1'b0};
      ge_xx  = tr_xx >= {1'b0, d2_q[k].den};
      ge_xy  = tr_xy >= {1'b0, d2_q[k].den};
      div2_d.rem_xx = ge_xx ? 126'(tr_xx - {1'b0, d2_q[k].den}) : tr_xx[125:0];
      div2_d.rem_xy = ge_xy ? 126'(tr_xy - {1'b0, d2_q[k].den}) : tr_xy[125:0];
      div2_d.q_xx   = {d2_q[k].q_xx[30:0], ge_xx};
      div2_d.q_xy   = {d2_q[k].q_xy[30:0], ge_xy};
    end

    always_ff @(posedge clk_i) begin
      d2_q[k+1] <= div2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= '0;
    else         v2_q <= {v2_q[QuotW-1:0], s5_valid_q};
  end

  // --------------------------------------------------------------------------
  // Output register: apply tensor signs, strobe the word
  // --------------------------------------------------------------------------
  div2_t d2_end;
  assign d2_end = d2_q[QuotW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= v2_q[QuotW];
  end

  always_ff @(posedge clk_i) begin
    eff_conductivity_o <= d2_end.s;
    eff_hall_coeff_o   <= d2_end.r;
    tensor_xx_o        <= d2_end.sneg ? 32'(~d2_end.q_xx + 1'b1) : d2_end.q_xx;
    tensor_xy_o        <= d2_end.rneg ? 32'(~d2_end.q_xy + 1'b1) : d2_end.q_xy;
    small_signal_o     <= d2_end.near_zero;
    saturated_o        <= d2_end.sat;
    sweep_last_o       <= d2_end.sweep;
  end

`ifndef NO_ASSERTIONS
  // A small-signal word carries zero conductivity and zero tensor values
  a_small_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && small_signal_o) |->
      (eff_conductivity_o == '0 && tensor_xx_o == '0 && tensor_xy_o == '0))
    else $error("small-signal result with nonzero conductivity or tensor");

  // The diagonal component keeps the sign of the conductivity
  a_xx_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && tensor_xx_o != '0) |-> (tensor_xx_o[31] == eff_conductivity_o[31]))
    else $error("tensor_xx sign differs from conductivity sign");

  // Zero conductivity forces both tensor components to zero
  a_zero_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && eff_conductivity_o == '0) |-> (tensor_xx_o == '0 && tensor_xy_o == '0))
    else $error("tensor nonzero with zero conductivity");
`endif

endmodule : hall_signal_to_conductivity_tensor_top
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Hall sample to conductivity tensor block. Every
// accepted sample is run through an exact integer predictor. Each result word
// is then compared with the oldest prediction. The run goes through several
// register settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import hstct_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 100;

  typedef struct {
    logic signed [VoltW-1:0] long_v;
    logic signed [VoltW-1:0] hall_v;
    logic                    last;
  } hall_sample_t;

  typedef struct {
    logic signed [OutW-1:0] cond;
    logic signed [OutW-1:0] hall;
    logic signed [OutW-1:0] txx;
    logic signed [OutW-1:0] txy;
    logic                   near_zero;
    logic                   sat;
    logic                   last;
  } tensor_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [VoltW-1:0] long_voltage_i = '0;
  logic signed [VoltW-1:0] hall_voltage_i = '0;
  logic sweep_end_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic valid_o;
  logic signed [OutW-1:0] eff_conductivity_o, eff_hall_coeff_o, tensor_xx_o, tensor_xy_o;
  logic small_signal_o, saturated_o, sweep_last_o;

  // Register copies used by the predictor
  logic [63:0] ratio_q = 64'(RatioRst);
  logic [63:0] thick_q = 64'(ThickRst);
  logic [63:0] cur_q   = 64'(CurRst);
  logic [63:0] lim_q   = 64'(LimRst);

  hall_sample_t pending_samples[$];
  tensor_word_t expected_words[$];
  int unsigned  idle_pct = 0;
  logic         hold_sender = 1'b0;
  int unsigned  mismatches = 0;
  int unsigned  words_seen = 0;
  int unsigned  samples_sent = 0;
  int unsigned  cycles = 0;

  hall_signal_to_conductivity_tensor_top uut (.*);

  always #6 clk_i = ~clk_i;

  // Apply sign and clip a magnitude to the 32 bit signed range
  function automatic longint clip32(logic [63:0] mag, logic neg, inout logic sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        mag = 64'h8000_0000;
      end
      return -longint'(mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      mag = 64'h7FFF_FFFF;
    end
    return longint'(mag);
  endfunction

  function automatic tensor_word_t predict_tensor(hall_sample_t smp);
    longint       v, h, s, r, sxx, sxy;
    logic [63:0]  thick, cur, vmag, hmag, smag, rmag, p, q;
    logic [127:0] den, num;
    logic         sat, near_zero;
    tensor_word_t res;
    v = smp.long_v;
    h = smp.hall_v;
    thick = (thick_q == 0) ? 64'd1 : thick_q;
    cur = (cur_q == 0) ? 64'd1 : cur_q;
    vmag = (v < 0) ? -v : v;
    hmag = (h < 0) ? -h : h;
    sat = 1'b0;
    near_zero = (vmag == 0) || (vmag < lim_q);
    s = 0;
    if (!near_zero) s = clip32((ratio_q * cur) / (thick * vmag), v < 0, sat);
    r = clip32(((thick * hmag) << 16) / cur, h < 0, sat);
    smag = (s < 0) ? -s : s;
    rmag = (r < 0) ? -r : r;
    p = smag * rmag;
    den = {64'd0, p} * {64'd0, p} + (128'd1 << 64);
    num = {smag, 64'd0};
    q = 64'(num / den);
    sxx = (s < 0) ? -longint'(q) : longint'(q);
    num = ({64'd0, smag} * {64'd0, p}) << 32;
    q = 64'(num / den);
    sxy = (r < 0) ? -longint'(q) : longint'(q);
    res.cond = s[31:0];
    res.hall = r[31:0];
    res.txx = sxx[31:0];
    res.txy = sxy[31:0];
    res.near_zero = near_zero;
    res.sat = sat;
    res.last = smp.last;
    return res;
  endfunction

  // Append one sample to the pending queue
  task automatic queue_sample(hall_sample_t smp);
    pending_samples = {pending_samples, smp};
  endtask

  // Driver: predict the word taken at this edge, then present the next one
  always @(posedge clk_i) begin
    hall_sample_t nxt;
    if (start_i && !busy_o) begin
      expected_words = {expected_words,
                        predict_tensor('{long_voltage_i, hall_voltage_i, sweep_end_i})};
      samples_sent++;
    end
    if (pending_samples.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
      nxt = pending_samples.pop_front();
      start_i <= 1'b1;
      long_voltage_i <= nxt.long_v;
      hall_voltage_i <= nxt.hall_v;
      sweep_end_i <= nxt.last;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    tensor_word_t exp_w;
    if (rst_ni && valid_o) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("result word with no prediction waiting");
        mismatches++;
      end else begin
        exp_w = expected_words.pop_front();
        if (eff_conductivity_o !== exp_w.cond) begin
          $error("eff_conductivity exp %0d got %0d", exp_w.cond, eff_conductivity_o);
          mismatches++;
        end
        if (eff_hall_coeff_o !== exp_w.hall) begin
          $error("eff_hall_coeff exp %0d got %0d", exp_w.hall, eff_hall_coeff_o);
          mismatches++;
        end
        if (tensor_xx_o !== exp_w.txx) begin
          $error("tensor_xx exp %0d got %0d", exp_w.txx, tensor_xx_o);
          mismatches++;
        end
        if (tensor_xy_o !== exp_w.txy) begin
          $error("tensor_xy exp %0d got %0d", exp_w.txy, tensor_xy_o);
          mismatches++;
        end
        if (small_signal_o !== exp_w.near_zero) begin
          $error("small_signal exp %0b got %0b", exp_w.near_zero, small_signal_o);
          mismatches++;
        end
        if (saturated_o !== exp_w.sat) begin
          $error("saturated exp %0b got %0b", exp_w.sat, saturated_o);
          mismatches++;
        end
        if (sweep_last_o !== exp_w.last) begin
          $error("sweep_last exp %0b got %0b", exp_w.last, sweep_last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LENGTH_RATIO:    ratio_q = 64'(data[RatioW-1:0]);
      CFG_FILM_THICKNESS:  thick_q = 64'(data[ThickW-1:0]);
      CFG_DRIVE_CURRENT:   cur_q = 64'(data[CurW-1:0]);
      CFG_NEAR_ZERO_LIMIT: lim_q = 64'(data[LimW-1:0]);
      default: ;
    endcase
  endtask

  // Send what is pending, hold the sender until every prediction is matched,
  // then let the pipe drain
  task automatic drain_block();
    while (pending_samples.size() > 0)
      @(posedge clk_i);
    hold_sender = 1'b1;
    while (expected_words.size() > 0 || start_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    hold_sender = 1'b0;
  endtask

  // Voltage with a random magnitude span so small and large values both occur
  function automatic logic signed [VoltW-1:0] rand_volt();
    logic [VoltW-1:0] raw;
    int unsigned      span;
    raw = $urandom;
    if ($urandom_range(3) == 0) return raw;
    span = $urandom_range(1, VoltW - 1);
    raw = raw & ((24'd1 << span) - 1);
    if ($urandom_range(1)) return -$signed(raw);
    return $signed(raw);
  endfunction

  task automatic add_random(int unsigned n);
    hall_sample_t smp;
    repeat (n) begin
      smp.long_v = rand_volt();
      // near the small signal threshold now and then
      if ($urandom_range(9) == 0) begin
        smp.long_v = $urandom_range(0, int'(lim_q) + 2);
        if ($urandom_range(1)) smp.long_v = -smp.long_v;
      end
      smp.hall_v = rand_volt();
      smp.last = ($urandom_range(7) == 0);
      queue_sample(smp);
    end
  endtask

  task automatic run_phase(logic [23:0] ratio, logic [23:0] thick, logic [23:0] cur,
                           logic [23:0] lim, int unsigned pct, int unsigned n);
    drain_block();
    write_reg(CFG_LENGTH_RATIO, ratio);
    write_reg(CFG_FILM_THICKNESS, thick);
    write_reg(CFG_DRIVE_CURRENT, cur);
    write_reg(CFG_NEAR_ZERO_LIMIT, lim);
    idle_pct = pct;
    add_random(n);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset settings: extremes, zero, below limit, both signs
    queue_sample('{24'sd0, 24'sd0, 1'b0});
    queue_sample('{24'sd1, 24'sd1, 1'b1});
    queue_sample('{-24'sd1, -24'sd1, 1'b0});
    queue_sample('{24'sh7FFFFF, 24'sh7FFFFF, 1'b0});
    queue_sample('{24'sh800000, 24'sh800000, 1'b1});
    queue_sample('{24'sh7FFFFF, 24'sh800000, 1'b0});
    queue_sample('{24'sh800000, 24'sh7FFFFF, 1'b0});
    queue_sample('{24'sd0, 24'sh7FFFFF, 1'b0});
    queue_sample('{24'sd1000, 24'sd0, 1'b0});
    queue_sample('{-24'sd1000, 24'sd500, 1'b0});
    queue_sample('{24'sd100000, -24'sd3, 1'b1});
    queue_sample('{24'sd7, 24'sd65, 1'b0});
    add_random(260);

    // Largest registers, heavy sender idling
    run_phase(24'hFFFFFF, 24'hFFFFF, 24'hFFFFF, 24'h3FF, 75, 270);
    queue_sample('{24'sd1023, 24'sd1, 1'b0});
    queue_sample('{-24'sd1022, 24'sd1, 1'b0});
    // Zero thickness and current read as one, limit zero
    run_phase($urandom, 24'd0, 24'd0, 24'd0, 0, 270);
    // Random settings, light idling
    run_phase($urandom, $urandom_range(1, 1048575), $urandom_range(1, 1048575),
              $urandom_range(0, 1023), 27, 270);
    // Smallest ratio, thickness and current with the largest limit, heavy idling
    run_phase(24'd0, 24'd1, 24'd1, 24'h3FF, 75, 270);
    drain_block();

    $display("tb_top: %0d samples sent, %0d result words checked over five register settings",
             samples_sent, words_seen);
    $display("tb_top: idle rates 0/75/27 percent, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
